// ===== rtl/tole_pkg.sv =====
package tole_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W    = 56;

    typedef enum logic [1:0] {
        OP_FRONT  = 2'd0,
        OP_BACK   = 2'd1,
        OP_SORTED = 2'd2,
        OP_LIST   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] event_time;
        logic [15:0] event_target;
        logic [7:0]  event_kind;
    } cmd_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_time;
        logic [15:0] out_target;
        logic [7:0]  out_kind;
        logic        last_of_run;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [15:0] ev_target;
        logic [7:0]  ev_kind;
    } entry_t;

endpackage

// ===== rtl/tole_ram.sv =====
module tole_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/time_ordered_event_list_top.sv =====
// The list of up to LIST_DEPTH events sits in one RAM, and every insert or
// list walks it one entry per clock through the single read port. An insert
// reads entries 0..count in turn, where count is the number of entries held
// before it, and from the insertion point on each is written back one place
// further down while the new item goes in. Its result strobes in the same
// cycle that busy falls. A list strobes one result per cycle, front first,
// with last_of_run on the final one. An insert into a full list and a list
// of an empty list answer in the cycle after the item is taken, without
// raising busy. Results are shown for a single cycle and must be taken then;
// a new item may be started while a result is shown.
module time_ordered_event_list_top
    import tole_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_item_t request,
    output rsp_item_t response,
    output logic      response_valid
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_INSERT = 3'b010,
        S_LIST   = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] rsp_idx_reg, rsp_idx_next;
    logic       rsp_vld_reg, rsp_vld_next;
    logic       placed_reg, placed_next;
    opcode_t    op_reg, op_next;
    entry_t     new_reg, new_next;
    entry_t     carry_reg, carry_next;
    rsp_item_t  out_reg, out_next;
    logic       out_vld_reg, out_vld_next;

    logic       issue;
    logic       ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t     ram_wdata;
    entry_t     ram_rdata;
    logic       accept;
    logic       hit;

    tole_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign busy           = (state_reg != S_IDLE);
    assign accept         = start && !busy;
    assign response       = out_reg;
    assign response_valid = out_vld_reg;

    assign issue = ((state_reg == S_INSERT) && (rd_idx_reg <= count_reg)) ||
                   ((state_reg == S_LIST) && (rd_idx_reg < count_reg));

    assign hit = (op_reg == OP_FRONT) ||
                 ((op_reg == OP_SORTED) && (ram_rdata.ev_time >= new_reg.ev_time));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        rsp_idx_next = rd_idx_reg;
        rsp_vld_next = issue;
        placed_next  = placed_reg;
        op_next      = op_reg;
        new_next     = new_reg;
        carry_next   = carry_reg;
        out_next     = out_reg;
        out_vld_next = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = rsp_idx_reg[IDX_W-1:0];
        ram_wdata    = new_reg;

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next           = request.opcode;
                    new_next.ev_time  = request.event_time;
                    new_next.ev_target = request.event_target;
                    new_next.ev_kind  = request.event_kind;
                    rd_idx_next       = '0;
                    placed_next       = 1'b0;
                    out_next          = '0;
                    out_next.last_of_run = 1'b1;
                    if (request.opcode == OP_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            out_next.status = ST_EMPTY;
                            out_vld_next    = 1'b1;
                        end
                        else
                        begin
                            state_next = S_LIST;
                        end
                    end
                    else if (count_reg == CNT_W'(LIST_DEPTH))
                    begin
                        out_next.status = ST_FULL;
                        out_vld_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                if (rsp_vld_reg)
                begin
                    if (rsp_idx_reg == count_reg)
                    begin
                        // One past the old tail: the list grows by one here.
                        ram_we       = 1'b1;
                        ram_wdata    = placed_reg ? carry_reg : new_reg;
                        count_next   = count_reg + CNT_W'(1);
                        state_next   = S_IDLE;
                        out_next     = '0;
                        out_next.status = ST_OK;
                        out_next.last_of_run = 1'b1;
                        out_vld_next = 1'b1;
                    end
                    else if (placed_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = carry_reg;
                        carry_next = ram_rdata;
                    end
                    else if (hit)
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = new_reg;
                        carry_next  = ram_rdata;
                        placed_next = 1'b1;
                    end
                end
            end
            S_LIST:
            begin
                if (rsp_vld_reg)
                begin
                    out_next.status      = ST_OK;
                    out_next.out_time    = ram_rdata.ev_time;
                    out_next.out_target  = ram_rdata.ev_target;
                    out_next.out_kind    = ram_rdata.ev_kind;
                    out_next.last_of_run = ((rsp_idx_reg + CNT_W'(1)) == count_reg);
                    out_vld_next         = 1'b1;
                    if ((rsp_idx_reg + CNT_W'(1)) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            rsp_vld_reg <= 1'b0;
            placed_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            rsp_vld_reg <= rsp_vld_next;
            placed_reg  <= placed_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_idx_reg <= rsp_idx_next;
        op_reg      <= op_next;
        new_reg     <= new_next;
        carry_reg   <= carry_next;
        out_reg     <= out_next;
    end

    // The list never holds more entries than the store has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    // The count moves only at the end of an insert walk, and then by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_INSERT) && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count changed outside an insert");

    // Every walk ends with its final result on the ports.
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (response_valid && response.last_of_run))
        else $error("walk finished without a final result");

    // Entries produced during a list walk always carry ok status.
    a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (response_valid && ($past(state_reg) == S_LIST)) |-> (response.status == ST_OK))
        else $error("listed entry with non-ok status");

    // No read response is pending once the block is idle.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rsp_vld_reg)
        else $error("read response left over in idle");

endmodule

// ===== sim/tb_time_ordered_event_list_top.sv =====
module tb_time_ordered_event_list_top
    import tole_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int TAIL_CYCLES    = 40;

    // Shadow copy of the event list and the replies that it predicts.
    class event_list_model;
        entry_t    shadow_list[$];
        rsp_item_t expected_replies[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function void apply_command(cmd_item_t c);
            rsp_item_t r;
            entry_t    e;
            int        pos;
            r = '0;
            r.status = ST_OK;
            if (c.opcode == OP_LIST)
            begin
                if (shadow_list.size() == 0)
                begin
                    r.status      = ST_EMPTY;
                    r.last_of_run = 1'b1;
                    expected_replies.push_back(r);
                end
                else
                begin
                    foreach (shadow_list[i])
                    begin
                        r.out_time    = shadow_list[i].ev_time;
                        r.out_target  = shadow_list[i].ev_target;
                        r.out_kind    = shadow_list[i].ev_kind;
                        r.last_of_run = (i == shadow_list.size() - 1);
                        expected_replies.push_back(r);
                    end
                end
            end
            else
            begin
                r.last_of_run = 1'b1;
                if (shadow_list.size() >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    e.ev_time   = c.event_time;
                    e.ev_target = c.event_target;
                    e.ev_kind   = c.event_kind;
                    if (c.opcode == OP_FRONT)
                    begin
                        pos = 0;
                    end
                    else if (c.opcode == OP_BACK)
                    begin
                        pos = shadow_list.size();
                    end
                    else
                    begin
                        // The new event goes ahead of any entry with an equal time,
                        // and the head entry is tested like the rest.
                        pos = 0;
                        while (pos < shadow_list.size() &&
                               shadow_list[pos].ev_time < e.ev_time)
                            pos++;
                    end
                    shadow_list.insert(pos, e);
                end
                expected_replies.push_back(r);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_reply(rsp_item_t got);
            rsp_item_t want;
            if (expected_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, got);
            end
            else
            begin
                want = expected_replies.pop_front();
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("out_time", want.out_time, got.out_time);
                compare_field("out_target", 32'(want.out_target), 32'(got.out_target));
                compare_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
                compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    cmd_item_t request = '0;
    rsp_item_t response;
    logic      response_valid;

    event_list_model model;
    bit              no_gaps;
    int              idle_cycles = 0;

    time_ordered_event_list_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .response       (response),
        .response_valid (response_valid)
    );

    always #1 clk = ~clk;

    // Items and results are both taken at the rising edge, so both are noted here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (response_valid === 1'b1)
                model.check_reply(response);
            if (start && busy === 1'b0)
                model.apply_command(request);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || response_valid === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic cmd_item_t make_cmd(opcode_t op, logic [31:0] t, logic [15:0] tg,
                                           logic [7:0] k);
        cmd_item_t c;
        c.opcode       = op;
        c.event_time   = t;
        c.event_target = tg;
        c.event_kind   = k;
        return c;
    endfunction

    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            c.opcode = OP_LIST;
        else
            c.opcode = opcode_t'(2'($urandom_range(0, 2)));
        // A small pool of whole-second times makes equal times common.
        case ($urandom_range(0, 9))
            0:       c.event_time = 32'h0000_0000;
            1:       c.event_time = 32'hffff_ffff;
            2, 3, 4: c.event_time = {16'($urandom_range(0, 3)), 16'h0000};
            default: c.event_time = $urandom;
        endcase
        c.event_target = 16'($urandom_range(0, 65535));
        c.event_kind   = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Called at a rising edge; returns at the edge that takes the item, or after a random gap with start dropped.
    task automatic issue_command(cmd_item_t c);
        int gap;
        int roll;
        request <= c;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 50)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        model   = new();
        no_gaps = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_command(make_cmd(OP_LIST, 32'h0, 16'h0, 8'h0));
        issue_command(make_cmd(OP_FRONT, 32'h0001_0000, 16'h0001, 8'h01));
        issue_command(make_cmd(OP_BACK, 32'hffff_ffff, 16'hffff, 8'hff));
        // Sorted inserts that land at the head, among equal times and before the tail.
        issue_command(make_cmd(OP_SORTED, 32'h0000_0000, 16'h0000, 8'h00));
        issue_command(make_cmd(OP_SORTED, 32'h0001_0000, 16'h1234, 8'h12));
        issue_command(make_cmd(OP_SORTED, 32'h0001_8000, 16'h5a5a, 8'ha5));
        issue_command(make_cmd(OP_SORTED, 32'hffff_ffff, 16'ha5a5, 8'h5a));
        issue_command(make_cmd(OP_LIST, 32'hffff_ffff, 16'hffff, 8'hff));
        issue_command(make_cmd(OP_FRONT, 32'h8000_0000, 16'h00ff, 8'h0f));
        issue_command(make_cmd(OP_SORTED, 32'h0000_8000, 16'hff00, 8'hf0));
        issue_command(make_cmd(OP_BACK, 32'h0000_0000, 16'h8001, 8'h80));
        issue_command(make_cmd(OP_LIST, 32'h0, 16'h0, 8'h0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 32 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            issue_command(random_command());
        end
        start <= 1'b0;

        while (model.expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (model.errors == 0 && model.expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tole_pkg.sv
rtl/tole_ram.sv
rtl/time_ordered_event_list_top.sv
sim/tb_time_ordered_event_list_top.sv
